// ===== hdl/gafs_pkg.sv =====
// Package with shared constants, types and codes of the grid A* block.
`timescale 1ns / 1ps
package gafs_pkg;
    localparam int MaxWidth   = 64;
    localparam int MaxHeight  = 64;
    localparam int CellCount  = MaxWidth * MaxHeight;
    localparam int CellBits   = $clog2(CellCount);
    localparam int OpenDepth  = 16384;
    localparam int OpenBits   = $clog2(OpenDepth);
    localparam int CntBits    = OpenBits + 1;
    localparam int CoordBits  = 6;
    localparam int DimBits    = 7;
    localparam int CostBits   = 13;
    localparam int FBits      = 14;
    localparam int SeqBits    = 14;
    localparam logic [CostBits-1:0] Unreached = '1;

    localparam int EntryBits = FBits + SeqBits + CostBits + 2 * CoordBits;

    typedef struct packed {
        logic [FBits-1:0]     f;
        logic [SeqBits-1:0]   seq;
        logic [CostBits-1:0]  cost;
        logic [CoordBits-1:0] pa;
        logic [CoordBits-1:0] pb;
    } t_entry;

    localparam logic [2:0] StepAPlus  = 3'd0;
    localparam logic [2:0] StepAMinus = 3'd1;
    localparam logic [2:0] StepBPlus  = 3'd2;
    localparam logic [2:0] StepBMinus = 3'd3;
    localparam logic [2:0] StepNoPath = 3'd4;
    localparam logic [2:0] StepAtGoal = 3'd5;

    localparam logic [1:0] DirAMinus = 2'd0;
    localparam logic [1:0] DirAPlus  = 2'd1;
    localparam logic [1:0] DirBMinus = 2'd2;
    localparam logic [1:0] DirBPlus  = 2'd3;

    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    localparam logic OpWrite  = 1'b0;
    localparam logic OpSearch = 1'b1;

    // Result code for a first step taken in direction d.
    function automatic logic [2:0] step_of_dir(input logic [1:0] d);
        logic [2:0] s;
        unique case (d)
            DirAMinus: s = StepAMinus;
            DirAPlus:  s = StepAPlus;
            DirBMinus: s = StepBMinus;
            default:   s = StepBPlus;
        endcase
        return s;
    endfunction

    function automatic logic [CoordBits-1:0] adiff(input logic [CoordBits-1:0] x,
                                                   input logic [CoordBits-1:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    // Heap order: smaller f first, then older push first.
    function automatic logic goes_first(input t_entry x, input t_entry y);
        return (x.f != y.f) ? (x.f < y.f) : (x.seq < y.seq);
    endfunction
endpackage

// ===== hdl/gafs_if.sv =====
// Valid/ready channel interface carrying one item.
`timescale 1ns / 1ps
interface gafs_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [11:0] cell_index;
    logic       is_wall;
    logic [5:0] start_a;
    logic [5:0] start_b;
    logic [5:0] goal_a;
    logic [5:0] goal_b;
    modport source (output valid, opcode, cell_index, is_wall, start_a, start_b, goal_a,
                    goal_b, input ready);
    modport sink (input valid, opcode, cell_index, is_wall, start_a, start_b, goal_a,
                  goal_b, output ready);
endinterface

interface gafs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] step_code;
    modport source (output valid, step_code, input ready);
    modport sink (input valid, step_code, output ready);
endinterface

// ===== hdl/gafs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gafs_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/grid_astar_first_step.sv =====
// Top level of the grid A* first-step search block.
// Usage: items arrive on in_ch. A write item (opcode 0) stores one wall bit
// and produces no result; the next item can be taken in the following cycle.
// A search item (opcode 1) produces one step_code item on out_ch.
// A search first clears the cost store (one entry per cycle), seeds the
// start cell and pushes it, then pops and expands heap
// entries. Each pop sifts down over the heap memory level by level through
// S_SDRD, S_SDRD2 and S_SDCMP; each push sifts up through S_SURD and S_SUCMP.
// Start equals goal or an off-grid cell gives its result through state
// S_OUT into the output register. The heap memory, with one read per
// cycle, sets the pace of every heap step.
// After reset all 4096 entries of the wall map are cleared while no item is
// taken; configuration writes are accepted at any time when idle.
// The result waits in an output register; while the receiver stalls the
// block accepts no further item. Reset returns width and height to 64.
`timescale 1ns / 1ps
module grid_astar_first_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    gafs_in_if.sink     in_ch,
    gafs_out_if.source  out_ch
);
    import gafs_pkg::*;

    typedef enum logic [16:0] {
        S_WCLR   = 17'h00001,
        S_IDLE   = 17'h00002,
        S_CLR    = 17'h00004,
        S_POP    = 17'h00008,
        S_POPW   = 17'h00010,
        S_SDRD   = 17'h00020,
        S_SDCMP  = 17'h00040,
        S_NBR    = 17'h00080,
        S_NBRW   = 17'h00100,
        S_NBRCHK = 17'h00200,
        S_SURD   = 17'h00400,
        S_SUCMP  = 17'h00800,
        S_TRRD   = 17'h01000,
        S_TRW    = 17'h02000,
        S_TRCHK  = 17'h04000,
        S_OUT    = 17'h08000,
        S_SDRD2  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    logic [DimBits-1:0] r_w, r_h;
    logic [DimBits-1:0] w_eff, h_eff;
    assign w_eff = (r_w == '0) ? DimBits'(1) : (r_w > DimBits'(MaxWidth)) ?
                   DimBits'(MaxWidth) : r_w;
    assign h_eff = (r_h == '0) ? DimBits'(1) : (r_h > DimBits'(MaxHeight)) ?
                   DimBits'(MaxHeight) : r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= DimBits'(MaxWidth);
            r_h <= DimBits'(MaxHeight);
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegWidth) r_w <= i_cfg_data;
            else r_h <= i_cfg_data;
        end
    end

    // Memories.
    logic                 wm_we, wm_wd, wm_rd;
    logic [CellBits-1:0]  wm_wa, wm_ra;
    logic                 bc_we;
    logic [CellBits-1:0]  bc_wa, bc_ra;
    logic [CostBits-1:0]  bc_wd, bc_rd;
    logic                 pd_we;
    logic [CellBits-1:0]  pd_wa, pd_ra;
    logic [1:0]           pd_wd, pd_rd;
    logic                 hp_we;
    logic [OpenBits-1:0]  hp_wa, hp_ra;
    t_entry               hp_wd, hp_rd;

    gafs_ram #(.Width(1), .Depth(CellCount)) u_wall (
        .i_clk, .i_we(wm_we), .i_waddr(wm_wa), .i_wdata(wm_wd), .i_raddr(wm_ra),
        .o_rdata(wm_rd));
    gafs_ram #(.Width(CostBits), .Depth(CellCount)) u_cost (
        .i_clk, .i_we(bc_we), .i_waddr(bc_wa), .i_wdata(bc_wd), .i_raddr(bc_ra),
        .o_rdata(bc_rd));
    gafs_ram #(.Width(2), .Depth(CellCount)) u_par (
        .i_clk, .i_we(pd_we), .i_waddr(pd_wa), .i_wdata(pd_wd), .i_raddr(pd_ra),
        .o_rdata(pd_rd));
    gafs_ram #(.Width(EntryBits), .Depth(OpenDepth)) u_heap (
        .i_clk, .i_we(hp_we), .i_waddr(hp_wa), .i_wdata(hp_wd), .i_raddr(hp_ra),
        .o_rdata(hp_rd));

    // Search registers.
    logic [CellBits:0]    r_cnt, n_cnt;
    logic [CoordBits-1:0] r_sa, r_sb, r_ga, r_gb, n_sa, n_sb, n_ga, n_gb;
    logic [CntBits-1:0]   r_open, n_open;
    logic [SeqBits-1:0]   r_seq, n_seq;
    t_entry               r_cur, n_cur, r_last, n_last, r_new, n_new, r_c1, n_c1;
    logic [OpenBits-1:0]  r_i, n_i, r_c, n_c;
    logic [2:0]           r_k, n_k;
    logic [CoordBits:0]   r_na, r_nb, n_na, n_nb;
    logic [CellBits-1:0]  r_idx, n_idx;
    logic [CoordBits-1:0] r_ta, r_tb, n_ta, n_tb;
    logic [2:0]           r_code, n_code;
    logic                 r_ovalid, n_ovalid;
    logic                 r_heap_op, n_heap_op;

    logic [CellBits-1:0] lin_in;

    // Row-major index of (x, y) with the current width.
    function automatic logic [CellBits-1:0] lin(input logic [CoordBits-1:0] x,
                                                input logic [CoordBits-1:0] y,
                                                input logic [DimBits-1:0] w);
        logic [CellBits+DimBits-1:0] p;
        p = (CellBits+DimBits)'(x) * (CellBits+DimBits)'(w) + (CellBits+DimBits)'(y);
        return p[CellBits-1:0];
    endfunction

    assign lin_in = lin(r_na[CoordBits-1:0], r_nb[CoordBits-1:0], w_eff);

    logic [CoordBits:0] mva, mvb;
    always_comb begin
        mva = r_cur.pa + 7'd0;
        mvb = r_cur.pb + 7'd0;
        unique case (r_k[1:0])
            DirAMinus: mva = {1'b0, r_cur.pa} - 7'd1;
            DirAPlus:  mva = {1'b0, r_cur.pa} + 7'd1;
            DirBMinus: mvb = {1'b0, r_cur.pb} - 7'd1;
            default:   mvb = {1'b0, r_cur.pb} + 7'd1;
        endcase
    end

    logic [CoordBits:0] tpa, tpb;
    always_comb begin
        tpa = {1'b0, r_ta};
        tpb = {1'b0, r_tb};
        unique case (pd_rd)
            DirAMinus: tpa = {1'b0, r_ta} + 7'd1;
            DirAPlus:  tpa = {1'b0, r_ta} - 7'd1;
            DirBMinus: tpb = {1'b0, r_tb} + 7'd1;
            default:   tpb = {1'b0, r_tb} - 7'd1;
        endcase
    end

    logic accept;
    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ovalid;
    assign out_ch.step_code = r_code;

    logic [CostBits-1:0] nd;
    assign nd = r_cur.cost + CostBits'(1);

    logic [OpenBits:0] c2;
    logic [OpenBits-1:0] up;
    assign c2 = {r_i, 1'b1};
    assign up = (r_i - OpenBits'(1)) >> 1;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt;
        n_sa = r_sa; n_sb = r_sb; n_ga = r_ga; n_gb = r_gb;
        n_open = r_open; n_seq = r_seq; n_cur = r_cur; n_last = r_last;
        n_new = r_new; n_c1 = r_c1; n_i = r_i; n_c = r_c; n_k = r_k;
        n_na = r_na; n_nb = r_nb; n_idx = r_idx; n_ta = r_ta; n_tb = r_tb;
        n_code = r_code; n_ovalid = r_ovalid; n_heap_op = r_heap_op;
        wm_we = 1'b0; wm_wa = r_cnt[CellBits-1:0]; wm_wd = 1'b0; wm_ra = lin_in;
        bc_we = 1'b0; bc_wa = r_cnt[CellBits-1:0]; bc_wd = Unreached; bc_ra = lin_in;
        pd_we = 1'b0; pd_wa = r_idx; pd_wd = r_k[1:0];
        pd_ra = lin(r_ta, r_tb, w_eff);
        hp_we = 1'b0; hp_wa = r_i; hp_wd = r_new; hp_ra = r_i;
        if (r_ovalid && out_ch.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_WCLR: begin
                wm_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (CellBits+1)'(CellCount - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_ch.opcode == OpWrite) begin
                        wm_we = 1'b1;
                        wm_wa = in_ch.cell_index[CellBits-1:0];
                        wm_wd = in_ch.is_wall;
                    end else begin
                        n_sa = in_ch.start_a; n_sb = in_ch.start_b;
                        n_ga = in_ch.goal_a; n_gb = in_ch.goal_b;
                        if ({1'b0, in_ch.start_a} >= h_eff || {1'b0, in_ch.start_b} >= w_eff ||
                            {1'b0, in_ch.goal_a} >= h_eff || {1'b0, in_ch.goal_b} >= w_eff) begin
                            n_code = StepNoPath; n_state = S_OUT;
                        end else if (in_ch.start_a == in_ch.goal_a &&
                                     in_ch.start_b == in_ch.goal_b) begin
                            n_code = StepAtGoal; n_state = S_OUT;
                        end else begin
                            n_cnt = '0; n_state = S_CLR;
                        end
                    end
                end
            end
            S_CLR: begin
                bc_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (CellBits+1)'(CellCount)) begin
                    // Every entry is cleared; seed the start cell and push it.
                    bc_wa = lin(r_sa, r_sb, w_eff);
                    bc_wd = '0;
                    hp_we = 1'b1; hp_wa = '0;
                    hp_wd = '{f: FBits'(adiff(r_sa, r_ga)) + FBits'(adiff(r_sb, r_gb)),
                              seq: '0, cost: '0, pa: r_sa, pb: r_sb};
                    n_open = CntBits'(1); n_seq = SeqBits'(1);
                    n_i = '0; n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_open == '0) begin
                    n_code = StepNoPath; n_state = S_OUT;
                end else begin
                    hp_ra = '0;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_cur = hp_rd;
                hp_ra = r_open[OpenBits-1:0] - OpenBits'(1);
                n_open = r_open - 1'b1;
                n_i = '0;
                n_state = S_SDRD;
            end
            S_SDRD: begin
                // On the first visit after S_POPW, hp_rd holds the former last entry.
                if (r_heap_op == 1'b0) begin
                    n_last = hp_rd; n_heap_op = 1'b1;
                end
                if (r_open == '0) begin
                    n_state = S_NBR; n_k = '0; n_heap_op = 1'b0;
                end else if (c2 >= r_open) begin
                    hp_we = 1'b1; hp_wa = r_i;
                    hp_wd = (r_heap_op == 1'b0) ? hp_rd : r_last;
                    n_state = S_NBR; n_k = '0; n_heap_op = 1'b0;
                end else begin
                    hp_ra = c2[OpenBits-1:0];
                    n_state = S_SDRD2;
                end
            end
            S_SDRD2: begin
                n_c1 = hp_rd;
                n_c = c2[OpenBits-1:0];
                hp_ra = c2[OpenBits-1:0] + OpenBits'(1);
                n_state = S_SDCMP;
            end
            S_SDCMP: begin
                t_entry bc;
                logic [OpenBits-1:0] bi;
                bc = r_c1; bi = r_c;
                if ((OpenBits+1)'(r_c) + (OpenBits+1)'(1) < r_open &&
                    goes_first(hp_rd, r_c1)) begin
                    bc = hp_rd; bi = r_c + OpenBits'(1);
                end
                hp_we = 1'b1; hp_wa = r_i;
                if (goes_first(bc, r_last)) begin
                    hp_wd = bc; n_i = bi; n_state = S_SDRD;
                end else begin
                    hp_wd = r_last; n_state = S_NBR; n_k = '0; n_heap_op = 1'b0;
                end
            end
            S_NBR: begin
                if (r_cur.pa == r_ga && r_cur.pb == r_gb) begin
                    n_ta = r_ga; n_tb = r_gb; n_cnt = '0; n_state = S_TRRD;
                end else if (r_k == 3'd4) begin
                    n_state = S_POP;
                end else begin
                    n_na = mva; n_nb = mvb;
                    if (mva[CoordBits] || mvb[CoordBits] || mva >= h_eff || mvb >= w_eff) begin
                        n_k = r_k + 1'b1;
                    end else begin
                        n_state = S_NBRW;
                    end
                end
            end
            S_NBRW: begin
                n_idx = lin_in;
                n_state = S_NBRCHK;
            end
            S_NBRCHK: begin
                n_k = r_k + 1'b1;
                n_state = S_NBR;
                if (!wm_rd && nd < bc_rd && r_open != CntBits'(OpenDepth)) begin
                    bc_we = 1'b1; bc_wa = r_idx; bc_wd = nd;
                    pd_we = 1'b1;
                    n_new = '{f: FBits'(nd) + FBits'(adiff(r_na[CoordBits-1:0], r_ga)) +
                                 FBits'(adiff(r_nb[CoordBits-1:0], r_gb)),
                              seq: r_seq, cost: nd, pa: r_na[CoordBits-1:0],
                              pb: r_nb[CoordBits-1:0]};
                    n_seq = r_seq + 1'b1;
                    n_i = r_open[OpenBits-1:0];
                    n_open = r_open + 1'b1;
                    n_k = r_k;
                    n_state = S_SURD;
                end
            end
            S_SURD: begin
                if (r_i == '0) begin
                    hp_we = 1'b1;
                    n_k = r_k + 1'b1; n_state = S_NBR;
                end else begin
                    hp_ra = up;
                    n_state = S_SUCMP;
                end
            end
            S_SUCMP: begin
                hp_we = 1'b1;
                if (goes_first(r_new, hp_rd)) begin
                    hp_wd = hp_rd; n_i = up; n_state = S_SURD;
                end else begin
                    n_k = r_k + 1'b1; n_state = S_NBR;
                end
            end
            S_TRRD: begin
                n_state = S_TRW;
            end
            S_TRW: begin
                n_state = S_TRCHK;
            end
            S_TRCHK: begin
                n_cnt = r_cnt + 1'b1;
                if (tpa[CoordBits-1:0] == r_sa && tpb[CoordBits-1:0] == r_sb &&
                    !tpa[CoordBits] && !tpb[CoordBits]) begin
                    n_code = step_of_dir(pd_rd); n_state = S_OUT;
                end else if (tpa[CoordBits] || tpb[CoordBits] || tpa >= h_eff ||
                             tpb >= w_eff || r_cnt == (CellBits+1)'(CellCount - 1)) begin
                    n_code = StepNoPath; n_state = S_OUT;
                end else begin
                    n_ta = tpa[CoordBits-1:0]; n_tb = tpb[CoordBits-1:0];
                    n_state = S_TRRD;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WCLR; r_cnt <= '0; r_ovalid <= 1'b0;
            r_open <= '0; r_seq <= '0; r_heap_op <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_ovalid <= n_ovalid;
            r_open <= n_open; r_seq <= n_seq; r_heap_op <= n_heap_op;
        end
        r_sa <= n_sa; r_sb <= n_sb; r_ga <= n_ga; r_gb <= n_gb;
        r_cur <= n_cur; r_last <= n_last; r_new <= n_new; r_c1 <= n_c1;
        r_i <= n_i; r_c <= n_c; r_k <= n_k; r_na <= n_na; r_nb <= n_nb;
        r_idx <= n_idx; r_ta <= n_ta; r_tb <= n_tb; r_code <= n_code;
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("item taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> (r_ovalid && $stable(r_code)))
        else $error("result lost under stall");
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= CntBits'(OpenDepth)) else $error("heap overflow");
endmodule
